// ----- rtl/core/pnwf_pkg.sv -----
// Package for the peak novelty window filter: beat payload types, request codes,
// the internal command format and the command queue status.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package pnwf_pkg;

    // Request codes carried in req_type.
    localparam logic [1:0] REQ_CLEAR = 2'd0;
    localparam logic [1:0] REQ_LOAD  = 2'd1;
    localparam logic [1:0] REQ_QUERY = 2'd2;

    // Input beat.
    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] mass_value;
        logic [23:0] time_value;
        logic [31:0] mass_tolerance;
    } pnwf_in_t;

    // Result beat.
    typedef struct packed {
        logic [31:0] peak_index;
        logic        is_new;
    } pnwf_out_t;

    // Operations that survive classification in the front end.
    typedef enum logic [1:0] {
        OP_CLEAR,
        OP_LOAD,
        OP_QUERY
    } cmd_op_t;

    // One queued command.
    typedef struct packed {
        cmd_op_t     op;
        logic [31:0] mass;
        logic [23:0] rtime;
        logic [31:0] mtol;
    } cmd_t;

    // Command queue status seen by both sides.
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

`default_nettype wire

// ----- rtl/core/pnwf_front.sv -----
// Front end of the peak novelty window filter: accepts request beats, drops the
// unused request code and turns the rest into queued commands.
// Depends on pnwf_pkg.
`default_nettype none

module pnwf_front (
    input  wire logic               start,
    input  wire pnwf_pkg::pnwf_in_t request,
    input  wire pnwf_pkg::q_stat_t  q_stat,
    output logic                    busy,
    output logic                    push,
    output pnwf_pkg::cmd_t          cmd
);
    import pnwf_pkg::*;

    logic known_code;

    // A beat is taken whenever the queue has room; an unknown code is taken and dropped.
    assign busy = q_stat.full;

    always_comb
    begin
        known_code = request.req_type inside {REQ_CLEAR, REQ_LOAD, REQ_QUERY};
        push       = start && !q_stat.full && known_code;
        cmd.mass   = request.mass_value;
        cmd.rtime  = request.time_value;
        cmd.mtol   = request.mass_tolerance;
        case (request.req_type)
            REQ_CLEAR: cmd.op = OP_CLEAR;
            REQ_LOAD:  cmd.op = OP_LOAD;
            REQ_QUERY: cmd.op = OP_QUERY;
            default:   cmd.op = OP_CLEAR;
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/core/pnwf_queue.sv -----
// Short command queue between the front and back ends of the peak novelty
// window filter; the head entry is visible without a read delay.
// Depends on pnwf_pkg.
`default_nettype none

module pnwf_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire pnwf_pkg::cmd_t    push_cmd,
    input  wire logic              pop,
    output pnwf_pkg::cmd_t         head,
    output pnwf_pkg::q_stat_t      q_stat
);
    import pnwf_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
    localparam logic [NW-1:0] FULL_N = NW'(DEPTH);

    cmd_t          slots [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0] fill_reg, fill_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= push_cmd;
        end
    end

    assign head         = slots[rd_ptr_reg];
    assign q_stat.full  = (fill_reg == FULL_N);
    assign q_stat.empty = (fill_reg == '0);

endmodule

`default_nettype wire

// ----- rtl/core/pnwf_back.sv -----
// Back end of the peak novelty window filter: executes clear, load and query
// commands against the reference memory and produces the result strobe.
// Depends on pnwf_pkg.
`default_nettype none

module pnwf_back #(
    parameter int MAX_REFS = 1024
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [23:0]       rt_tolerance,
    input  wire pnwf_pkg::q_stat_t q_stat,
    input  wire pnwf_pkg::cmd_t    head,
    output logic                   pop,
    output logic                   done,
    output pnwf_pkg::pnwf_out_t    result
);
    import pnwf_pkg::*;

    localparam int AW = (MAX_REFS > 1) ? $clog2(MAX_REFS) : 1;
    localparam int CW = $clog2(MAX_REFS + 1);
    localparam logic [CW-1:0] CAP = CW'(MAX_REFS);

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    typedef struct packed {
        logic [31:0] mass;
        logic [23:0] rtime;
    } ref_entry_t;

    // Reference memory: one write port, one registered read port.
    ref_entry_t    ref_mem [MAX_REFS];
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    ref_entry_t    wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    ref_entry_t    rd_data_reg;

    state_t        state_reg, state_next;
    logic [CW-1:0] ref_count_reg, ref_count_next;
    logic [31:0]   query_count_reg, query_count_next;
    logic [CW-1:0] issue_idx_reg, issue_idx_next;
    logic          data_vld_reg, data_vld_next;
    cmd_t          sample_reg, sample_next;
    logic          done_reg, done_next;
    pnwf_out_t     result_reg, result_next;

    logic [31:0]   q_inc;
    logic [31:0]   mass_gap;
    logic [23:0]   time_gap;
    logic          hit;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ref_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= ref_mem[rd_addr];
        end
    end

    always_comb
    begin
        mass_gap = (sample_reg.mass >= rd_data_reg.mass) ? sample_reg.mass - rd_data_reg.mass
                                                         : rd_data_reg.mass - sample_reg.mass;
        time_gap = (sample_reg.rtime >= rd_data_reg.rtime)
                   ? sample_reg.rtime - rd_data_reg.rtime
                   : rd_data_reg.rtime - sample_reg.rtime;
        hit      = (mass_gap <= sample_reg.mtol) && (time_gap <= rt_tolerance);
        q_inc    = (query_count_reg != '1) ? query_count_reg + 32'd1 : query_count_reg;
    end

    always_comb
    begin
        state_next       = state_reg;
        ref_count_next   = ref_count_reg;
        query_count_next = query_count_reg;
        issue_idx_next   = issue_idx_reg;
        data_vld_next    = 1'b0;
        sample_next      = sample_reg;
        done_next        = 1'b0;
        result_next      = result_reg;
        pop              = 1'b0;
        wr_en            = 1'b0;
        wr_addr          = ref_count_reg[AW-1:0];
        wr_data.mass     = head.mass;
        wr_data.rtime    = head.rtime;
        rd_en            = 1'b0;
        rd_addr          = issue_idx_reg[AW-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    pop = 1'b1;
                    case (head.op)
                        OP_CLEAR:
                        begin
                            ref_count_next   = '0;
                            query_count_next = '0;
                        end
                        OP_LOAD:
                        begin
                            if (ref_count_reg < CAP)
                            begin
                                wr_en          = 1'b1;
                                ref_count_next = ref_count_reg + 1'b1;
                            end
                        end
                        OP_QUERY:
                        begin
                            query_count_next = q_inc;
                            sample_next      = head;
                            if (ref_count_reg == '0)
                            begin
                                done_next              = 1'b1;
                                result_next.peak_index = q_inc;
                                result_next.is_new     = 1'b1;
                            end
                            else
                            begin
                                state_next     = ST_SCAN;
                                issue_idx_next = '0;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                // Reads run one entry ahead of the compare on the registered data.
                if (issue_idx_reg < ref_count_reg)
                begin
                    rd_en          = 1'b1;
                    issue_idx_next = issue_idx_reg + 1'b1;
                    data_vld_next  = 1'b1;
                end
                if (data_vld_reg)
                begin
                    if (hit)
                    begin
                        done_next              = 1'b1;
                        result_next.peak_index = query_count_reg;
                        result_next.is_new     = 1'b0;
                        data_vld_next          = 1'b0;
                        state_next             = ST_IDLE;
                    end
                    else if (issue_idx_reg == ref_count_reg)
                    begin
                        done_next              = 1'b1;
                        result_next.peak_index = query_count_reg;
                        result_next.is_new     = 1'b1;
                        state_next             = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            ref_count_reg   <= '0;
            query_count_reg <= '0;
            issue_idx_reg   <= '0;
            data_vld_reg    <= 1'b0;
            sample_reg      <= '0;
            done_reg        <= 1'b0;
            result_reg      <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            ref_count_reg   <= ref_count_next;
            query_count_reg <= query_count_next;
            issue_idx_reg   <= issue_idx_next;
            data_vld_reg    <= data_vld_next;
            sample_reg      <= sample_next;
            done_reg        <= done_next;
            result_reg      <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

// ----- rtl/core/peak_novelty_window_filter_core.sv -----
// Top level of the peak novelty window filter: configuration register, front
// end, command queue and back end, plus the block's assertions.
// Depends on pnwf_pkg, pnwf_front, pnwf_queue and pnwf_back.
`default_nettype none

// Channel     Ports                          Beat taken when
// ---------   ----------------------------   ---------------------------------
// request     start, busy, request           start high and busy low
// result      done, result                   done high (one cycle, no stall)
// config      cfg_valid, cfg_ready, cfg_data cfg_valid and cfg_ready high
//
// A clear or a load is done as the back end pops it. A query walks the N stored
// references in load order, stops early when a match ends the scan and answers at once
// on an empty table; the result strobe is registered. The scan is paced by the reference
// memory, which delivers one entry per cycle on its read port.
// Reset clears the reference count, query counter and tolerance at once; the memory
// itself needs no clearing since only the counted entries are ever read.
// busy rises only when the command queue is full; the result side cannot stall.

module peak_novelty_window_filter_core #(
    parameter int MAX_REFS    = 1024,
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire pnwf_pkg::pnwf_in_t  request,
    output logic                     done,
    output pnwf_pkg::pnwf_out_t      result,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [23:0]         cfg_data
);
    import pnwf_pkg::*;

    // Retention-time tolerance. It must be written only while the block is idle,
    // so the back end can read it directly in a scan; the block does not enforce it.
    logic [23:0] rt_tol_reg;

    logic        push;
    cmd_t        push_cmd;
    cmd_t        head;
    q_stat_t     q_stat;
    logic        pop;

    // The configuration register takes a beat in every cycle.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rt_tol_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            rt_tol_reg <= cfg_data;
        end
    end

    // The front end classifies each accepted beat; unknown codes never reach the queue.
    pnwf_front u_front (
        .start   (start),
        .request (request),
        .q_stat  (q_stat),
        .busy    (busy),
        .push    (push),
        .cmd     (push_cmd)
    );

    // The queue lets new beats arrive while the back end is busy scanning.
    pnwf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .q_stat   (q_stat)
    );

    // The back end owns the reference memory, the counters and the result register.
    pnwf_back #(
        .MAX_REFS (MAX_REFS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .rt_tolerance (rt_tol_reg),
        .q_stat       (q_stat),
        .head         (head),
        .pop          (pop),
        .done         (done),
        .result       (result)
    );

`ifndef ASSERT_OFF
    // A command is never written into a full queue.
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_stat.full)
        else $error("command pushed into full queue");

    // The back end never takes a command from an empty queue.
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_stat.empty)
        else $error("command popped from empty queue");

    // A push without a pop leaves at least one command waiting.
    a_push_fills: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> !q_stat.empty)
        else $error("queue empty after push");

    // Every result carries a running index of at least one.
    a_index_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.peak_index != 32'd0))
        else $error("result with zero peak index");
`endif

endmodule

`default_nettype wire

// ----- tb/peak_novelty_window_filter_core_tb.sv -----
// Self-checking testbench for peak_novelty_window_filter_core: random-gap request beats,
// an in-bench novelty predictor, and a result monitor with field-by-field compares.
// Depends on pnwf_pkg and the RTL of the core; it needs no other file.
`timescale 1ns / 1ps

module peak_novelty_window_filter_core_tb;

    import pnwf_pkg::*;

    // The block keeps its default capacity; the tables built here stay below it.
    localparam int MAX_REFS = 1024;

    // Request code 3 has no meaning in the block and must be dropped without a trace.
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    // Clears and loads are done as the back end pops them and the command queue is four deep,
    // so this many quiet cycles after the last result leave the back end empty.
    localparam int DRAIN_CYCLES = 64;

    // The slowest correct run is roughly 580 beats, each a query that walks a full
    // table after a sender gap; about five times the length of that run is the cap.
    localparam int unsigned LIMIT_CYCLES = 3_000_000;

    logic         clk       = 1'b0;
    logic         rst_n     = 1'b0;
    logic         start     = 1'b0;
    pnwf_in_t     request   = '0;
    logic         cfg_valid = 1'b0;
    logic [23:0]  cfg_data  = '0;
    logic         busy;
    logic         done;
    pnwf_out_t    result;
    logic         cfg_ready;

    // Stimulus side: beats waiting for the driver and the counts that tell the
    // sequencer when every one of them has been taken by the block.
    pnwf_in_t     request_backlog[$];
    int unsigned  beats_queued = 0;
    int unsigned  beats_taken  = 0;
    logic         steady_traffic = 1'b0;

    // Predictor state: the reference peaks, their count, the running query number
    // and the retention-time window currently programmed into the block.
    logic [31:0]  ref_mass_mem[MAX_REFS];
    logic [23:0]  ref_time_mem[MAX_REFS];
    int unsigned  ref_fill     = 0;
    logic [31:0]  query_number = '0;
    logic [23:0]  rt_window    = '0;
    pnwf_out_t    pending_verdicts[$];

    // Generator copy of the references loaded since the last clear; it only steers
    // queries toward stored peaks and plays no part in checking.
    logic [31:0]  gen_mass[$];
    logic [23:0]  gen_time[$];
    logic [23:0]  phase_rt = '0;

    int unsigned  mismatch_count = 0;
    int unsigned  cycle_count    = 0;

    peak_novelty_window_filter_core #(
        .MAX_REFS (MAX_REFS)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    function automatic logic [31:0] mass_gap(input logic [31:0] a, input logic [31:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic logic [23:0] time_gap(input logic [23:0] a, input logic [23:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    // Applies one accepted request beat to the predictor. A query walks the stored
    // peaks in load order and is novel only if none sits inside both windows.
    task automatic predict_novelty(input pnwf_in_t req);
        pnwf_out_t   verdict;
        int unsigned k;
        case (req.req_type)
            REQ_CLEAR:
            begin
                ref_fill     = 0;
                query_number = '0;
            end
            REQ_LOAD:
            begin
                // A load into a full table is silently dropped.
                if (ref_fill < MAX_REFS)
                begin
                    ref_mass_mem[ref_fill] = req.mass_value;
                    ref_time_mem[ref_fill] = req.time_value;
                    ref_fill++;
                end
            end
            REQ_QUERY:
            begin
                // The running number sticks at all ones rather than wrapping.
                if (query_number != '1)
                    query_number++;
                verdict.peak_index = query_number;
                verdict.is_new     = 1'b1;
                for (k = 0; k < ref_fill; k++)
                begin
                    if (mass_gap(req.mass_value, ref_mass_mem[k]) <= req.mass_tolerance &&
                        time_gap(req.time_value, ref_time_mem[k]) <= rt_window)
                    begin
                        verdict.is_new = 1'b0;
                        break;
                    end
                end
                pending_verdicts.insert(pending_verdicts.size(), verdict);
            end
            default:
            begin
                // Code 3 is ignored entirely.
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Driver: presents backlog beats on start, holding each while busy is high.
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin : request_driver
        logic [95:0] junk;
        if (rst_n)
        begin
            // A beat moves when start is high and busy is low at this edge.
            if (start && !busy)
            begin
                predict_novelty(request);
                beats_taken++;
            end
            // With a beat still stalled, start and request must stay put.
            if (!start || !busy)
            begin
                if (request_backlog.size() != 0 &&
                    (steady_traffic || $urandom_range(99) >= 18))
                begin
                    start   <= 1'b1;
                    request <= request_backlog.pop_front();
                end
                else
                begin
                    // Scramble the idle payload so that a block that samples it
                    // without start shows up as a wrong result.
                    junk    = {$urandom(), $urandom(), $urandom()};
                    start   <= 1'b0;
                    request <= pnwf_in_t'(junk[$bits(pnwf_in_t)-1:0]);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: every done strobe is one result beat, checked against the oldest
    // expectation. The result side has no back-pressure, so nothing is held off.
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    always @(posedge clk)
    begin : result_monitor
        pnwf_out_t want;
        if (rst_n && done)
        begin
            if (pending_verdicts.size() == 0)
                report_mismatch($sformatf("result beat with nothing expected (index %0d new %0b)",
                                          result.peak_index, result.is_new));
            else
            begin
                want = pending_verdicts.pop_front();
                if (result.peak_index !== want.peak_index)
                    report_mismatch($sformatf("peak_index %0d, expected %0d",
                                              result.peak_index, want.peak_index));
                if (result.is_new !== want.is_new)
                    report_mismatch($sformatf("is_new %0b, expected %0b for query %0d",
                                              result.is_new, want.is_new, want.peak_index));
            end
        end
    end

    // Watchdog: a hung handshake or a lost result ends here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Appends one request beat to the backlog and keeps the steering copy current.
    task automatic queue_beat(input logic [1:0] kind, input logic [31:0] mass,
                              input logic [23:0] rtime, input logic [31:0] mtol);
        pnwf_in_t beat;
        beat.req_type       = kind;
        beat.mass_value     = mass;
        beat.time_value     = rtime;
        beat.mass_tolerance = mtol;
        request_backlog.insert(request_backlog.size(), beat);
        beats_queued++;
        if (kind == REQ_CLEAR)
        begin
            gen_mass.delete();
            gen_time.delete();
        end
        else if (kind == REQ_LOAD)
        begin
            gen_mass.insert(gen_mass.size(), mass);
            gen_time.insert(gen_time.size(), rtime);
        end
    endtask

    // Writes the retention-time window once the config channel accepts the beat.
    // Only called with the block idle, so the predictor copy may change at once.
    task automatic write_rt_window(input logic [23:0] value);
        while (!steady_traffic && $urandom_range(99) < 18)
            @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        rt_window = value;
        phase_rt  = value;
        cfg_valid <= 1'b0;
        cfg_data  <= 24'($urandom());
    endtask

    // Waits until every beat has been taken and every result has come back, then
    // lets the trailing clears and loads run out of the back end.
    task automatic settle_block();
        while (beats_taken != beats_queued)
            @(posedge clk);
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Loads a reference near the phase's cluster, now and then one anywhere.
    task automatic queue_cluster_load(input logic [31:0] base_mass, input logic [23:0] base_time);
        if ($urandom_range(9) == 0)
            queue_beat(REQ_LOAD, $urandom(), 24'($urandom()), $urandom());
        else
            queue_beat(REQ_LOAD, base_mass + $urandom_range(0, 4000),
                       24'(base_time + $urandom_range(0, 4000)), $urandom());
    endtask

    // A query aimed at a stored peak, with both distances placed on, just inside or
    // just outside the window edges so that matches and misses are both common.
    task automatic queue_near_query();
        int unsigned j;
        logic [31:0] d;
        logic [31:0] mtol;
        logic [24:0] t_off;
        logic [31:0] mass;
        logic [23:0] rtime;
        j = $urandom_range(gen_mass.size() - 1);
        d = $urandom_range(0, 300);
        case ($urandom_range(3))
            0: mtol = d;
            1: mtol = (d != 0) ? d - 1 : '0;
            2: mtol = d + $urandom_range(0, 50);
            default: mtol = $urandom();
        endcase
        mass = $urandom_range(1) ? gen_mass[j] + d : gen_mass[j] - d;
        case ($urandom_range(3))
            0: t_off = phase_rt;
            1: t_off = phase_rt + 25'd1;
            2: t_off = (phase_rt != 0) ? phase_rt - 25'd1 : '0;
            default: t_off = 25'($urandom_range(0, phase_rt));
        endcase
        rtime = $urandom_range(1) ? gen_time[j] + t_off[23:0] : gen_time[j] - t_off[23:0];
        queue_beat(REQ_QUERY, mass, rtime, mtol);
    endtask

    // One random beat: mostly queries at stored peaks, some loads and free-form queries,
    // a few clears and unused codes.
    task automatic queue_random_item(input logic [31:0] base_mass, input logic [23:0] base_time);
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 3)
            queue_beat(REQ_CLEAR, $urandom(), 24'($urandom()), $urandom());
        else if (pick < 6)
            queue_beat(REQ_UNUSED, $urandom(), 24'($urandom()), $urandom());
        else if (pick < 22)
            queue_cluster_load(base_mass, base_time);
        else if (pick < 80 && gen_mass.size() != 0)
            queue_near_query();
        else
            queue_beat(REQ_QUERY,
                       $urandom_range(1) ? $urandom() : base_mass + $urandom_range(0, 5000),
                       $urandom_range(1) ? 24'($urandom())
                                         : 24'(base_time + $urandom_range(0, 4000)),
                       $urandom_range(1) ? $urandom() : $urandom_range(0, 3000));
    endtask

    // A well-formed phase: clear, a small table around one cluster, then a mix
    // of queries and further traffic. Tables stay small to keep scans short.
    task automatic run_random_phase(input int unsigned n_items);
        logic [31:0] base_mass;
        logic [23:0] base_time;
        int unsigned first_beat;
        base_mass  = $urandom();
        base_time  = 24'($urandom());
        first_beat = beats_queued;
        queue_beat(REQ_CLEAR, $urandom(), 24'($urandom()), $urandom());
        repeat ($urandom_range(0, 40)) queue_cluster_load(base_mass, base_time);
        while (beats_queued - first_beat < n_items)
            queue_random_item(base_mass, base_time);
        settle_block();
    endtask

    // Builds a large table and queries both ends of it, so that scans walk
    // every stored entry as well as stop at the first one.
    task automatic run_long_scan_phase(input int unsigned n_refs);
        int unsigned k;
        logic [31:0] last_mass;
        logic [23:0] last_time;
        queue_beat(REQ_CLEAR, $urandom(), 24'($urandom()), $urandom());
        for (k = 0; k < n_refs; k++)
        begin
            last_mass = 32'h1000_0000 + k * 4096 + $urandom_range(0, 1000);
            last_time = 24'(k * 16);
            queue_beat(REQ_LOAD, last_mass, last_time, $urandom());
        end
        // The last peak loaded is found only after a full scan.
        queue_beat(REQ_QUERY, last_mass, last_time, '0);
        // A miss that walks every entry.
        queue_beat(REQ_QUERY, 32'hE000_0000, 24'($urandom()), 32'd4096);
        // The first peak ends the scan at once.
        queue_beat(REQ_QUERY, gen_mass[0], gen_time[0], 32'd0);
        repeat (6) queue_near_query();
        queue_beat(REQ_CLEAR, $urandom(), 24'($urandom()), $urandom());
        queue_beat(REQ_QUERY, last_mass, last_time, '1);
        settle_block();
    endtask

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed beats with the window still at its reset value of zero.
        queue_beat(REQ_QUERY, 32'd1000, 24'd500, '1);                  // empty table: new
        queue_beat(REQ_UNUSED, '1, '1, '1);
        queue_beat(REQ_LOAD, 32'd0, 24'd0, '1);
        queue_beat(REQ_LOAD, 32'hFFFF_FFFF, 24'hFF_FFFF, '0);
        queue_beat(REQ_LOAD, 32'd1000, 24'd500, $urandom());
        queue_beat(REQ_QUERY, 32'd1000, 24'd500, 32'd0);               // exact hit
        queue_beat(REQ_QUERY, 32'd1001, 24'd500, 32'd0);               // one off: miss
        queue_beat(REQ_QUERY, 32'd1001, 24'd500, 32'd1);               // on the edge: hit
        queue_beat(REQ_QUERY, 32'd1000, 24'd501, 32'd0);               // time one off: miss
        queue_beat(REQ_QUERY, 32'hFFFF_FFFF, 24'd0, 32'hFFFF_FFFF);    // widest mass window
        queue_beat(REQ_QUERY, 32'hFFFF_FFFF, 24'hFF_FFFF, 32'd0);      // top corner
        queue_beat(REQ_QUERY, 32'd0, 24'hFF_FFFF, 32'hFFFF_FFFF);      // full-width distance
        queue_beat(REQ_QUERY, 32'h8000_0000, 24'h80_0000, 32'h7FFF_FFFF);
        queue_beat(REQ_UNUSED, 32'd1000, 24'd500, 32'd0);
        queue_beat(REQ_CLEAR, '1, '1, '1);
        queue_beat(REQ_QUERY, 32'd1000, 24'd500, '1);                  // numbering restarts
        settle_block();

        // Widest window: every time distance fits.
        write_rt_window(24'hFF_FFFF);
        queue_beat(REQ_LOAD, 32'd5, 24'd0, '0);
        queue_beat(REQ_QUERY, 32'd5, 24'hFF_FFFF, 32'd0);
        queue_beat(REQ_QUERY, 32'd6, 24'd0, 32'd0);
        settle_block();

        write_rt_window(24'd0);
        run_random_phase(58);

        write_rt_window(24'd1);
        run_random_phase(58);

        // One phase runs back to back with no sender gaps.
        write_rt_window(24'($urandom_range(2, 5000)));
        steady_traffic = 1'b1;
        run_random_phase(58);
        steady_traffic = 1'b0;

        write_rt_window(24'($urandom()));
        run_random_phase(58);

        write_rt_window(24'hFF_FFFF);
        run_random_phase(58);

        write_rt_window(24'($urandom_range(0, 300)));
        run_long_scan_phase(200);

        write_rt_window(24'($urandom_range(0, 3000)));
        run_random_phase(60);

        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
